FILE: design/kpt_pkg.sv
`timescale 1ns / 1ps

package kpt_pkg;

    // Field widths of the update and result items
    localparam int KEY_W   = 48;
    localparam int LAT_W   = 28;
    localparam int LON_W   = 29;
    localparam int STAMP_W = 32;
    localparam int SPEED_W = 8;
    localparam int SLOT_W  = 4;
    localparam int REV_W   = 32;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_BITS   = KEY_W + LAT_W + LON_W + STAMP_W + SPEED_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = SLOT_W + 1 + 1 + REV_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } state_t;

endpackage

FILE: design/keyed_position_table_upsert.sv
`timescale 1ns / 1ps

// From the input transfer, the sequencer walks each filled entry through the shared
// key/stamp compare, then passes through a read drain state and the write state that loads
// the output register; an empty table skips the walk and goes straight to the write state.
// A new update is accepted only in idle, once the previous one is written; the write waits
// while the previous result is still held for m_tready.
// Reset (rst_n, async, active low) empties the table and clears the revision counter.
module keyed_position_table_upsert #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // node_key[47:0], latitude[75:48], longitude[104:76], stamp[136:105], speed[144:137]
    input  logic [kpt_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // slot_index[3:0], key_hit[4], evicted[5], revision[37:6]
    output logic [kpt_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int KS_W  = kpt_pkg::KEY_W + kpt_pkg::STAMP_W;
    localparam int PL_W  = kpt_pkg::LAT_W + kpt_pkg::LON_W + kpt_pkg::SPEED_W;

    localparam int LAT_LO   = kpt_pkg::KEY_W;
    localparam int LON_LO   = LAT_LO + kpt_pkg::LAT_W;
    localparam int STAMP_LO = LON_LO + kpt_pkg::LON_W;
    localparam int SPEED_LO = STAMP_LO + kpt_pkg::STAMP_W;

    kpt_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]              fill_reg, fill_next;
    logic [CNT_W-1:0]              issue_reg, issue_next;
    logic                          chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]              chk_idx_reg, chk_idx_next;
    logic [kpt_pkg::REV_W-1:0]     rev_reg, rev_next;
    logic                          out_valid_reg, out_valid_next;
    logic [kpt_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic [kpt_pkg::KEY_W-1:0]     in_key_reg;
    logic [kpt_pkg::LAT_W-1:0]     in_lat_reg;
    logic [kpt_pkg::LON_W-1:0]     in_lon_reg;
    logic [kpt_pkg::STAMP_W-1:0]   in_stamp_reg;
    logic [kpt_pkg::SPEED_W-1:0]   in_speed_reg;

    logic                          in_xfer;
    logic                          walk_clear;
    logic                          rd_en;
    logic                          wr_en;
    logic                          out_free;
    logic                          table_full;
    logic [IDX_W-1:0]              slot;
    logic                          evict;
    logic [KS_W-1:0]               ks_rd;
    logic                          walk_hit;
    logic [IDX_W-1:0]              walk_match;
    logic [IDX_W-1:0]              walk_old;

    assign in_xfer    = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign table_full = (fill_reg == CNT_W'(TABLE_ENTRIES));

    // Pick the slot: matched entry, next free entry, or the oldest one
    always_comb
    begin
        evict = 1'b0;
        if (walk_hit)
        begin
            slot = walk_match;
        end
        else if (!table_full)
        begin
            slot = fill_reg[IDX_W-1:0];
        end
        else
        begin
            slot  = walk_old;
            evict = 1'b1;
        end
    end

    // Sequencer: next state and control
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        issue_next     = issue_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        rev_next       = rev_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        s_tready       = 1'b0;
        walk_clear     = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        case (state_reg)
            kpt_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    walk_clear = 1'b1;
                    issue_next = '0;
                    state_next = (fill_reg == '0) ? kpt_pkg::ST_WRITE : kpt_pkg::ST_SCAN;
                end
            end
            kpt_pkg::ST_SCAN:
            begin
                // Issue one entry read a cycle
                rd_en          = 1'b1;
                chk_valid_next = 1'b1;
                chk_idx_next   = issue_reg[IDX_W-1:0];
                issue_next     = issue_reg + CNT_W'(1);
                if (issue_reg + CNT_W'(1) == fill_reg)
                begin
                    state_next = kpt_pkg::ST_DRAIN;
                end
            end
            kpt_pkg::ST_DRAIN:
            begin
                state_next = kpt_pkg::ST_WRITE;
            end
            kpt_pkg::ST_WRITE:
            begin
                // Commit once the output register can take the result
                if (out_free)
                begin
                    wr_en          = 1'b1;
                    rev_next       = rev_reg + kpt_pkg::REV_W'(1);
                    if (!walk_hit && !table_full)
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = kpt_pkg::OUT_DATA_W'({rev_next, evict, walk_hit,
                                                           kpt_pkg::SLOT_W'(slot)});
                    state_next     = kpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kpt_pkg::ST_IDLE;
            fill_reg      <= '0;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            rev_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the update fields and result payload
    always_ff @(posedge clk)
    begin
        chk_idx_reg  <= chk_idx_next;
        out_data_reg <= out_data_next;
        if (in_xfer)
        begin
            in_key_reg   <= s_tdata[LAT_LO-1:0];
            in_lat_reg   <= s_tdata[LON_LO-1:LAT_LO];
            in_lon_reg   <= s_tdata[STAMP_LO-1:LON_LO];
            in_stamp_reg <= s_tdata[SPEED_LO-1:STAMP_LO];
            in_speed_reg <= s_tdata[SPEED_LO+kpt_pkg::SPEED_W-1:SPEED_LO];
        end
    end

    // Key and stamp per entry, walked during the search
    kpt_ram #(
        .WIDTH (KS_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot),
        .wr_data ({in_stamp_reg, in_key_reg}),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (ks_rd)
    );

    // Latitude, longitude and speed per entry
    kpt_ram #(
        .WIDTH (PL_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot),
        .wr_data ({in_speed_reg, in_lon_reg, in_lat_reg}),
        .rd_en   (1'b0),
        .rd_addr ('0),
        .rd_data ()
    );

    // Shared match and oldest-stamp compare unit
    kpt_walk #(
        .IDX_W (IDX_W)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (walk_clear),
        .valid     (chk_valid_reg),
        .idx       (chk_idx_reg),
        .key_in    (in_key_reg),
        .key_rd    (ks_rd[kpt_pkg::KEY_W-1:0]),
        .stamp_rd  (ks_rd[KS_W-1:kpt_pkg::KEY_W]),
        .hit       (walk_hit),
        .match_idx (walk_match),
        .old_idx   (walk_old)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_tready)
        else $error("input taken while an update is in progress");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[4] && m_tdata[5]))
        else $error("result flags both hit and eviction");

    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[5]) |-> table_full)
        else $error("eviction reported with room in the table");
`endif

endmodule

FILE: design/kpt_ram.sv
`timescale 1ns / 1ps

module kpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered output
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/kpt_walk.sv
`timescale 1ns / 1ps

module kpt_walk #(
    parameter int IDX_W = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      valid,
    input  logic [IDX_W-1:0]          idx,
    input  logic [kpt_pkg::KEY_W-1:0] key_in,
    input  logic [kpt_pkg::KEY_W-1:0] key_rd,
    input  logic [kpt_pkg::STAMP_W-1:0] stamp_rd,
    output logic                      hit,
    output logic [IDX_W-1:0]          match_idx,
    output logic [IDX_W-1:0]          old_idx
);

    logic                        hit_reg, hit_next;
    logic                        first_reg, first_next;
    logic [IDX_W-1:0]            match_reg, match_next;
    logic [IDX_W-1:0]            old_reg, old_next;
    logic [kpt_pkg::STAMP_W-1:0] old_stamp_reg, old_stamp_next;
    logic                        key_eq;
    logic                        older;

    // Shared compare: key equality and unsigned stamp order, one entry a cycle
    assign key_eq = (key_rd == key_in);
    assign older  = first_reg || (stamp_rd < old_stamp_reg);

    always_comb
    begin
        hit_next       = hit_reg;
        first_next     = first_reg;
        match_next     = match_reg;
        old_next       = old_reg;
        old_stamp_next = old_stamp_reg;
        if (clear)
        begin
            hit_next   = 1'b0;
            first_next = 1'b1;
            match_next = '0;
            old_next   = '0;
        end
        else if (valid)
        begin
            // Keep the first match; strict order keeps the lowest index on ties
            if (!hit_reg && key_eq)
            begin
                hit_next   = 1'b1;
                match_next = idx;
            end
            if (older)
            begin
                old_next       = idx;
                old_stamp_next = stamp_rd;
            end
            first_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= 1'b0;
            first_reg <= 1'b1;
            match_reg <= '0;
            old_reg   <= '0;
        end
        else
        begin
            hit_reg   <= hit_next;
            first_reg <= first_next;
            match_reg <= match_next;
            old_reg   <= old_next;
        end
    end

    always_ff @(posedge clk)
    begin
        old_stamp_reg <= old_stamp_next;
    end

    assign hit       = hit_reg;
    assign match_idx = match_reg;
    assign old_idx   = old_reg;

endmodule

FILE: sim/keyed_position_table_upsert_test.sv
`timescale 1ns / 1ps

module keyed_position_table_upsert_test;

    localparam int ENTRIES        = 16;
    localparam int RANDOM_UPDATES = 1300;
    localparam int KEY_POOL       = 20;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int LONG_HOLD      = 400;
    localparam int LAT_LIMIT      = 90000000;
    localparam int LON_LIMIT      = 180000000;

    // One position update as it enters the block
    typedef struct {
        logic [kpt_pkg::KEY_W-1:0]          key;
        logic signed [kpt_pkg::LAT_W-1:0]   lat;
        logic signed [kpt_pkg::LON_W-1:0]   lon;
        logic [kpt_pkg::STAMP_W-1:0]        stamp;
        logic [kpt_pkg::SPEED_W-1:0]        speed;
    } update_t;

    // One report coming back from the block
    typedef struct {
        logic [kpt_pkg::SLOT_W-1:0] slot;
        logic                       hit;
        logic                       evicted;
        logic [kpt_pkg::REV_W-1:0]  revision;
    } report_t;

    // Directed row; typed rows carry their report, the rest go through the predictor
    typedef struct {
        logic [kpt_pkg::KEY_W-1:0]   key;
        int                          lat;
        int                          lon;
        logic [kpt_pkg::STAMP_W-1:0] stamp;
        logic [kpt_pkg::SPEED_W-1:0] speed;
        bit                          typed;
        logic [kpt_pkg::SLOT_W-1:0]  slot;
        bit                          hit;
        bit                          evicted;
        logic [kpt_pkg::REV_W-1:0]   revision;
    } dir_row_t;

    localparam int DIR_ROWS = 24;

    dir_row_t directed_rows [DIR_ROWS] = '{
        // empty table, then both key extremes, then hits on them
        '{48'h0, -90000000, -180000000, 32'h0, 8'd0, 1, 4'd0, 0, 0, 32'd1},
        '{48'hFFFF_FFFF_FFFF, 90000000, 180000000, 32'hFFFF_FFFF, 8'd255,
          1, 4'd1, 0, 0, 32'd2},
        '{48'h0, 1, -1, 32'd5, 8'd128, 1, 4'd0, 1, 0, 32'd3},
        '{48'hFFFF_FFFF_FFFF, -1, 1, 32'd7, 8'd1, 1, 4'd1, 1, 0, 32'd4},
        // fill the remaining slots; slots 3 and 9 tie on the oldest stamp
        '{48'h8000_0000_0000, 0, 0, 32'd100, 8'd17, 0, 4'd0, 0, 0, 32'd0},
        '{48'h0000_0000_0001, 12345678, -23456789, 32'd3, 8'd40, 0, 4'd0, 0, 0, 32'd0},
        '{48'h5555_5555_5555, -45000000, 90000000, 32'h8000_0000, 8'd60,
          0, 4'd0, 0, 0, 32'd0},
        '{48'hAAAA_AAAA_AAAA, 45000000, -90000000, 32'd200, 8'd90, 0, 4'd0, 0, 0, 32'd0},
        '{48'h0000_0000_0002, -1, -1, 32'd300, 8'd200, 0, 4'd0, 0, 0, 32'd0},
        '{48'h7FFF_FFFF_FFFF, 89999999, -179999999, 32'h7FFF_FFFF, 8'd254,
          0, 4'd0, 0, 0, 32'd0},
        '{48'hFFFF_FFFF_FFFE, -89999999, 179999999, 32'hFFFF_FFFE, 8'd2,
          0, 4'd0, 0, 0, 32'd0},
        '{48'h0000_0000_0003, 3, 3, 32'd3, 8'd3, 0, 4'd0, 0, 0, 32'd0},
        '{48'h0123_4567_89AB, 500, -500, 32'd400, 8'd80, 0, 4'd0, 0, 0, 32'd0},
        '{48'hFEDC_BA98_7654, -500, 500, 32'd401, 8'd81, 0, 4'd0, 0, 0, 32'd0},
        '{48'h0000_FFFF_0000, 1000000, 2000000, 32'd402, 8'd82, 0, 4'd0, 0, 0, 32'd0},
        '{48'hFFFF_0000_FFFF, -1000000, -2000000, 32'd403, 8'd83, 0, 4'd0, 0, 0, 32'd0},
        '{48'h00FF_00FF_00FF, 2, -2, 32'd404, 8'd84, 0, 4'd0, 0, 0, 32'd0},
        '{48'hFF00_FF00_FF00, -2, 2, 32'd405, 8'd85, 0, 4'd0, 0, 0, 32'd0},
        // full table: evict the lower tied slot, then the other one
        '{48'h1234_5678_9ABC, 10, 20, 32'd1000, 8'd100, 0, 4'd0, 0, 0, 32'd0},
        '{48'h0F0F_0F0F_0F0F, 30, 40, 32'd2000, 8'd110, 0, 4'd0, 0, 0, 32'd0},
        // hit while full, then evictions and a hit on a zero stamp
        '{48'hAAAA_AAAA_AAAA, 50, 60, 32'hFFFF_FFFF, 8'd120, 0, 4'd0, 0, 0, 32'd0},
        '{48'h0000_0000_0004, 70, 80, 32'd0, 8'd130, 0, 4'd0, 0, 0, 32'd0},
        '{48'h0000_0000_0004, 71, 81, 32'd0, 8'd131, 0, 4'd0, 0, 0, 32'd0},
        '{48'h0000_0000_0005, 72, 82, 32'd9, 8'd140, 0, 4'd0, 0, 0, 32'd0}
    };

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [kpt_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [kpt_pkg::OUT_DATA_W-1:0] m_tdata;

    // Predictor copy of the table: keys and stamps decide every report
    logic [kpt_pkg::KEY_W-1:0]   shadow_key   [ENTRIES];
    logic [kpt_pkg::STAMP_W-1:0] shadow_stamp [ENTRIES];
    int                          shadow_fill;
    logic [kpt_pkg::REV_W-1:0]   shadow_revision;

    report_t pending_reports [$];

    logic [kpt_pkg::KEY_W-1:0]   key_pool [KEY_POOL];
    logic [kpt_pkg::STAMP_W-1:0] stamp_clock;
    int burst_left;
    int mismatch_count;
    int reports_checked;
    int updates_sent;
    int hit_count;
    int append_count;
    int evict_count;
    int drain_count;
    int cycle_count;

    keyed_position_table_upsert #(
        .TABLE_ENTRIES(ENTRIES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Search for the key, else append, else replace the oldest stamp (lowest index on ties)
    function automatic report_t predict_upsert(input update_t u);
        report_t r;
        int      idx;
        bit      found;
        r     = '{default: '0};
        idx   = 0;
        found = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!found && i < shadow_fill && shadow_key[i] == u.key)
            begin
                idx   = i;
                found = 1'b1;
            end
        end
        if (found)
        begin
            hit_count++;
        end
        else if (shadow_fill < ENTRIES)
        begin
            idx = shadow_fill;
            shadow_fill++;
            append_count++;
        end
        else
        begin
            idx = 0;
            for (int i = 1; i < ENTRIES; i++)
            begin
                if (shadow_stamp[i] < shadow_stamp[idx])
                    idx = i;
            end
            r.evicted = 1'b1;
            evict_count++;
        end
        shadow_key[idx]   = u.key;
        shadow_stamp[idx] = u.stamp;
        shadow_revision   = shadow_revision + kpt_pkg::REV_W'(1);
        r.slot     = idx[kpt_pkg::SLOT_W-1:0];
        r.hit      = found;
        r.revision = shadow_revision;
        return r;
    endfunction

    // Coordinate in range, with the extremes now and then
    function automatic int pick_coord(input int limit);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return -limit;
        else if (pick == 1)
            return limit;
        else
            return int'($urandom_range(0, 2 * limit)) - limit;
    endfunction

    function automatic update_t random_update();
        update_t     u;
        logic [63:0] fresh;
        int          roll;
        fresh = {$urandom(), $urandom()};
        roll  = $urandom_range(0, 99);
        // Rotate a pool key now and then so every key bit keeps changing
        if (roll < 3)
            key_pool[$urandom_range(0, KEY_POOL - 1)] = fresh[kpt_pkg::KEY_W-1:0];
        if (roll < 12)
            u.key = fresh[kpt_pkg::KEY_W-1:0];
        else
            u.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        u.lat = kpt_pkg::LAT_W'(pick_coord(LAT_LIMIT));
        u.lon = kpt_pkg::LON_W'(pick_coord(LON_LIMIT));
        // Mix wide stamps, a crowded low band for ties, and a slowly rising clock
        case ($urandom_range(0, 3))
            0, 1:    u.stamp = $urandom();
            2:       u.stamp = $urandom_range(0, 3);
            default:
            begin
                stamp_clock = stamp_clock + $urandom_range(0, 5);
                u.stamp     = stamp_clock;
            end
        endcase
        u.speed = kpt_pkg::SPEED_W'($urandom_range(0, 255));
        return u;
    endfunction

    // Offer one update and hold it until the transfer, then queue its report
    task automatic offer_update(input update_t u, input bit typed, input report_t typed_rep);
        logic [kpt_pkg::IN_DATA_W-1:0] word;
        report_t                       predicted;
        word = '0;
        word[kpt_pkg::IN_BITS-1:0] = {u.speed, u.stamp, u.lon, u.lat, u.key};
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_upsert(u);
        pending_reports.push_back(typed ? typed_rep : predicted);
        updates_sent++;
    endtask

    // Continue the burst, or start a new burst, first dropping valid for a random gap unless the gap is zero
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        drain_count++;
    endtask

    task automatic note_mismatch(input string what, input report_t want, input report_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: want slot=%0d hit=%0b evicted=%0b rev=%0d,%s%0d %0b %0b %0d",
                     what, want.slot, want.hit, want.evicted, want.revision,
                     " got slot/hit/evicted/rev=",
                     got.slot, got.hit, got.evicted, got.revision);
    endtask

    // Check each result transfer against the oldest pending report
    always @(posedge clk)
    begin : check_reports
        report_t got;
        report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.slot     = m_tdata[kpt_pkg::SLOT_W-1:0];
            got.hit      = m_tdata[kpt_pkg::SLOT_W];
            got.evicted  = m_tdata[kpt_pkg::SLOT_W+1];
            got.revision = m_tdata[kpt_pkg::SLOT_W+2 +: kpt_pkg::REV_W];
            if (pending_reports.size() == 0)
            begin
                note_mismatch("report with none pending", '{default: '0}, got);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.slot !== want.slot || got.hit !== want.hit ||
                    got.evicted !== want.evicted || got.revision !== want.revision)
                    note_mismatch("report mismatch", want, got);
            end
            reports_checked++;
        end
    end

    // Receiver: stretches of steady, random and sparse ready, plus one long hold-off
    initial
    begin : receiver
        int  mode;
        int  stretch;
        int  hold;
        bit  long_done;
        m_tready  = 1'b0;
        stretch   = 0;
        mode      = 0;
        hold      = 0;
        long_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (!long_done && reports_checked >= 300)
            begin
                long_done = 1'b1;
                hold      = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    mode    = $urandom_range(0, 2);
                    stretch = $urandom_range(20, 200);
                end
                stretch--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Run limit
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped at the cycle limit with %0d reports pending",
                 pending_reports.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        update_t u;
        report_t typed_rep;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        rst_n           = 1'b0;
        shadow_fill     = 0;
        shadow_revision = '0;
        stamp_clock     = $urandom();
        burst_left      = 0;
        mismatch_count  = 0;
        reports_checked = 0;
        updates_sent    = 0;
        hit_count       = 0;
        append_count    = 0;
        evict_count     = 0;
        drain_count     = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_key[i]   = '0;
            shadow_stamp[i] = '0;
        end
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = kpt_pkg::KEY_W'({$urandom(), $urandom()});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            u.key              = directed_rows[r].key;
            u.lat              = kpt_pkg::LAT_W'(directed_rows[r].lat);
            u.lon              = kpt_pkg::LON_W'(directed_rows[r].lon);
            u.stamp            = directed_rows[r].stamp;
            u.speed            = directed_rows[r].speed;
            typed_rep.slot     = directed_rows[r].slot;
            typed_rep.hit      = directed_rows[r].hit;
            typed_rep.evicted  = directed_rows[r].evicted;
            typed_rep.revision = directed_rows[r].revision;
            offer_update(u, directed_rows[r].typed, typed_rep);
            pace_sender();
        end
        hold_until_drained();

        // Random updates, pausing once midway until every pending report has come back
        for (int n = 0; n < RANDOM_UPDATES; n++)
        begin
            if (n == RANDOM_UPDATES / 2)
                hold_until_drained();
            u = random_update();
            offer_update(u, 1'b0, '{default: '0});
            pace_sender();
        end

        hold_until_drained();
        repeat (40) @(posedge clk);

        $display("Sent %0d updates and checked %0d reports", updates_sent, reports_checked);
        $display("Saw %0d key hits, %0d appends and %0d evictions; drained %0d times, %s%0d",
                 hit_count, append_count, evict_count, drain_count,
                 "receiver held off once for cycles: ", LONG_HOLD);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
